// File: hdl/rbfi_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and face/lane index helpers for the ray box face unit.
package rbfi_pkg;

	localparam int NUM_AXES  = 3;
	localparam int NUM_FACES = 6;
	localparam int NUM_LANES = 12;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MAX_X = 3'd1,
		REG_MIN_Y = 3'd2,
		REG_MAX_Y = 3'd3,
		REG_MIN_Z = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	function automatic int face_axis(input int k);
		return k >> 1;
	endfunction

	function automatic int lane_face(input int l);
		return l >> 1;
	endfunction

	function automatic int other_axis(input int a, input int j);
		if (j == 0) begin
			return (a == 0) ? 1 : 0;
		end
		return (a == 2) ? 1 : 2;
	endfunction

	function automatic int lane_other(input int l);
		return other_axis(l >> 2, l & 1);
	endfunction

endpackage

// File: hdl/rbfi_front.sv
`timescale 1ns / 1ps
// Front stages: ray direction, plane offsets, cross products and divider setup.
module rbfi_front #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [W-1:0]  start_p [rbfi_pkg::NUM_AXES],
	input  logic signed [W-1:0]  end_p [rbfi_pkg::NUM_AXES],
	input  logic signed [W-1:0]  box_lo [rbfi_pkg::NUM_AXES],
	input  logic signed [W-1:0]  box_hi [rbfi_pkg::NUM_AXES],
	output logic                 valid_s3,
	output logic [W:0]           rem_s3 [rbfi_pkg::NUM_LANES],
	output logic [W:0]           low_s3 [rbfi_pkg::NUM_LANES],
	output logic [W:0]           dvs_s3 [rbfi_pkg::NUM_LANES],
	output logic                 ovf_s3 [rbfi_pkg::NUM_LANES],
	output logic                 neg_s3 [rbfi_pkg::NUM_LANES],
	output logic signed [W-1:0]  sb_s3 [rbfi_pkg::NUM_LANES],
	output logic                 zero_s3 [rbfi_pkg::NUM_FACES],
	output logic                 behind_s3 [rbfi_pkg::NUM_FACES],
	output logic signed [W-1:0]  plane_s3 [rbfi_pkg::NUM_FACES]
);

	localparam int DW = W + 1;
	localparam int PW = 2 * DW;

	logic                valid_s1;
	logic signed [W-1:0] start_s1 [rbfi_pkg::NUM_AXES];
	logic signed [W:0]   dv_s1 [rbfi_pkg::NUM_AXES];
	logic signed [W:0]   dp_s1 [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] plane_s1 [rbfi_pkg::NUM_FACES];

	logic [W:0]          mag_dv [rbfi_pkg::NUM_AXES];
	logic [W:0]          mag_dp [rbfi_pkg::NUM_FACES];

	logic                valid_s2;
	logic [PW-1:0]       prod_s2 [rbfi_pkg::NUM_LANES];
	logic [W:0]          dvs_s2 [rbfi_pkg::NUM_FACES];
	logic                neg_s2 [rbfi_pkg::NUM_LANES];
	logic signed [W-1:0] sb_s2 [rbfi_pkg::NUM_LANES];
	logic                zero_s2 [rbfi_pkg::NUM_FACES];
	logic                behind_s2 [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] plane_s2 [rbfi_pkg::NUM_FACES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < rbfi_pkg::NUM_AXES; a++) begin
				start_s1[a] <= start_p[a];
				dv_s1[a]    <= DW'(end_p[a]) - DW'(start_p[a]);
			end
			for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
				plane_s1[k] <= k[0] ? box_hi[rbfi_pkg::face_axis(k)]
				                    : box_lo[rbfi_pkg::face_axis(k)];
				dp_s1[k] <= DW'(k[0] ? box_hi[rbfi_pkg::face_axis(k)]
				                     : box_lo[rbfi_pkg::face_axis(k)])
				          - DW'(start_p[rbfi_pkg::face_axis(k)]);
			end
		end
	end

	always_comb begin
		for (int a = 0; a < rbfi_pkg::NUM_AXES; a++) begin
			mag_dv[a] = dv_s1[a][W] ? (~dv_s1[a] + 1'b1) : dv_s1[a];
		end
		for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
			mag_dp[k] = dp_s1[k][W] ? (~dp_s1[k] + 1'b1) : dp_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
				prod_s2[l] <= PW'(mag_dv[rbfi_pkg::lane_other(l)])
				            * PW'(mag_dp[rbfi_pkg::lane_face(l)]);
				neg_s2[l]  <= dv_s1[rbfi_pkg::lane_other(l)][W]
				            ^ dp_s1[rbfi_pkg::lane_face(l)][W]
				            ^ dv_s1[rbfi_pkg::face_axis(rbfi_pkg::lane_face(l))][W];
				sb_s2[l]   <= start_s1[rbfi_pkg::lane_other(l)];
			end
			for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
				dvs_s2[k]    <= mag_dv[rbfi_pkg::face_axis(k)];
				zero_s2[k]   <= (dv_s1[rbfi_pkg::face_axis(k)] == '0);
				behind_s2[k] <= (dp_s1[k] != '0)
				             && (dp_s1[k][W] != dv_s1[rbfi_pkg::face_axis(k)][W]);
				plane_s2[k]  <= plane_s1[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
				rem_s3[l] <= prod_s2[l][PW-1:DW];
				low_s3[l] <= prod_s2[l][DW-1:0];
				dvs_s3[l] <= dvs_s2[rbfi_pkg::lane_face(l)];
				ovf_s3[l] <= (prod_s2[l][PW-1:DW] >= dvs_s2[rbfi_pkg::lane_face(l)]);
				neg_s3[l] <= neg_s2[l];
				sb_s3[l]  <= sb_s2[l];
			end
			for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
				zero_s3[k]   <= zero_s2[k];
				behind_s3[k] <= behind_s2[k];
				plane_s3[k]  <= plane_s2[k];
			end
		end
	end

endmodule

// File: hdl/rbfi_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage for all twelve lanes.
module rbfi_div #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic [W:0]           rem_in [rbfi_pkg::NUM_LANES],
	input  logic [W:0]           low_in [rbfi_pkg::NUM_LANES],
	input  logic [W:0]           dvs_in [rbfi_pkg::NUM_LANES],
	input  logic                 ovf_in [rbfi_pkg::NUM_LANES],
	input  logic                 neg_in [rbfi_pkg::NUM_LANES],
	input  logic signed [W-1:0]  sb_in [rbfi_pkg::NUM_LANES],
	input  logic                 zero_in [rbfi_pkg::NUM_FACES],
	input  logic                 behind_in [rbfi_pkg::NUM_FACES],
	input  logic signed [W-1:0]  plane_in [rbfi_pkg::NUM_FACES],
	output logic                 valid_out,
	output logic [W:0]           quo_out [rbfi_pkg::NUM_LANES],
	output logic                 rnz_out [rbfi_pkg::NUM_LANES],
	output logic                 ovf_out [rbfi_pkg::NUM_LANES],
	output logic                 neg_out [rbfi_pkg::NUM_LANES],
	output logic signed [W-1:0]  sb_out [rbfi_pkg::NUM_LANES],
	output logic                 zero_out [rbfi_pkg::NUM_FACES],
	output logic                 behind_out [rbfi_pkg::NUM_FACES],
	output logic signed [W-1:0]  plane_out [rbfi_pkg::NUM_FACES]
);

	localparam int DW = W + 1;

	typedef struct packed {
		logic [W:0]   rem;
		logic [W:0]   low;
		logic [W:0]   quo;
		logic [W:0]   dvs;
		logic         ovf;
		logic         neg;
		logic [W-1:0] sb;
	} lane_t;

	typedef struct packed {
		logic         zero;
		logic         behind;
		logic [W-1:0] plane;
	} face_t;

	function automatic lane_t div_step(input lane_t x);
		logic [W+1:0] t;
		logic [W+1:0] diff;
		logic         ge;
		lane_t        y;
		t    = {x.rem, x.low[W]};
		diff = t - {1'b0, x.dvs};
		ge   = (t >= {1'b0, x.dvs});
		y     = x;
		y.rem = ge ? diff[W:0] : t[W:0];
		y.low = {x.low[W-1:0], 1'b0};
		y.quo = {x.quo[W-1:0], ge};
		return y;
	endfunction

	lane_t lane_in [rbfi_pkg::NUM_LANES];
	face_t face_in [rbfi_pkg::NUM_FACES];

	logic  valid_s [DW];
	lane_t lane_s [DW][rbfi_pkg::NUM_LANES];
	face_t face_s [DW][rbfi_pkg::NUM_FACES];

	always_comb begin
		for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
			lane_in[l].rem = rem_in[l];
			lane_in[l].low = low_in[l];
			lane_in[l].quo = '0;
			lane_in[l].dvs = dvs_in[l];
			lane_in[l].ovf = ovf_in[l];
			lane_in[l].neg = neg_in[l];
			lane_in[l].sb  = sb_in[l];
		end
		for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
			face_in[k].zero   = zero_in[k];
			face_in[k].behind = behind_in[k];
			face_in[k].plane  = plane_in[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DW; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= valid_in;
			for (int i = 1; i < DW; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
				lane_s[0][l] <= div_step(lane_in[l]);
				for (int i = 1; i < DW; i++) begin
					lane_s[i][l] <= div_step(lane_s[i-1][l]);
				end
			end
			for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
				face_s[0][k] <= face_in[k];
				for (int i = 1; i < DW; i++) begin
					face_s[i][k] <= face_s[i-1][k];
				end
			end
		end
	end

	assign valid_out = valid_s[DW-1];

	always_comb begin
		for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
			quo_out[l] = lane_s[DW-1][l].quo;
			rnz_out[l] = (lane_s[DW-1][l].rem != '0);
			ovf_out[l] = lane_s[DW-1][l].ovf;
			neg_out[l] = lane_s[DW-1][l].neg;
			sb_out[l]  = lane_s[DW-1][l].sb;
		end
		for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
			zero_out[k]   = face_s[DW-1][k].zero;
			behind_out[k] = face_s[DW-1][k].behind;
			plane_out[k]  = face_s[DW-1][k].plane;
		end
	end

endmodule

// File: hdl/rbfi_back.sv
`timescale 1ns / 1ps
// Back stages: signed floor quotient, crossing points, bounds test and hit selection.
module rbfi_back #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic [W:0]           quo [rbfi_pkg::NUM_LANES],
	input  logic                 rnz [rbfi_pkg::NUM_LANES],
	input  logic                 ovf [rbfi_pkg::NUM_LANES],
	input  logic                 neg [rbfi_pkg::NUM_LANES],
	input  logic signed [W-1:0]  sb [rbfi_pkg::NUM_LANES],
	input  logic                 zero [rbfi_pkg::NUM_FACES],
	input  logic                 behind [rbfi_pkg::NUM_FACES],
	input  logic signed [W-1:0]  plane [rbfi_pkg::NUM_FACES],
	input  logic signed [W-1:0]  box_lo [rbfi_pkg::NUM_AXES],
	input  logic signed [W-1:0]  box_hi [rbfi_pkg::NUM_AXES],
	output logic                 valid_s4,
	output logic [1:0]           hit_count_s4,
	output logic signed [W-1:0]  first_s4 [rbfi_pkg::NUM_AXES],
	output logic                 first_behind_s4,
	output logic signed [W-1:0]  second_s4 [rbfi_pkg::NUM_AXES],
	output logic                 second_behind_s4
);

	localparam int CW = W + 3;

	logic                valid_s1;
	logic signed [W+1:0] qs_s1 [rbfi_pkg::NUM_LANES];
	logic                ovf_s1 [rbfi_pkg::NUM_LANES];
	logic signed [W-1:0] sb_s1 [rbfi_pkg::NUM_LANES];
	logic                zero_s1 [rbfi_pkg::NUM_FACES];
	logic                behind_s1 [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] plane_s1 [rbfi_pkg::NUM_FACES];

	logic                valid_s2;
	logic signed [CW-1:0] c_s2 [rbfi_pkg::NUM_LANES];
	logic                ovf_s2 [rbfi_pkg::NUM_LANES];
	logic                zero_s2 [rbfi_pkg::NUM_FACES];
	logic                behind_s2 [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] plane_s2 [rbfi_pkg::NUM_FACES];

	logic                inb [rbfi_pkg::NUM_LANES];

	logic                valid_s3;
	logic                hit_s3 [rbfi_pkg::NUM_FACES];
	logic                behind_s3 [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] pt_s3 [rbfi_pkg::NUM_FACES][rbfi_pkg::NUM_AXES];

	logic [1:0]          sel_cnt;
	logic signed [W-1:0] sel_first [rbfi_pkg::NUM_AXES];
	logic signed [W-1:0] sel_second [rbfi_pkg::NUM_AXES];
	logic                sel_first_behind;
	logic                sel_second_behind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// A negative quotient rounds toward minus infinity when the remainder is nonzero.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
				qs_s1[l]  <= neg[l] ? (~{1'b0, quo[l]} + (W+2)'(!rnz[l])) : {1'b0, quo[l]};
				ovf_s1[l] <= ovf[l];
				sb_s1[l]  <= sb[l];
			end
			for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
				zero_s1[k]   <= zero[k];
				behind_s1[k] <= behind[k];
				plane_s1[k]  <= plane[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
				c_s2[l]   <= CW'(sb_s1[l]) + CW'(qs_s1[l]);
				ovf_s2[l] <= ovf_s1[l];
			end
			for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
				zero_s2[k]   <= zero_s1[k];
				behind_s2[k] <= behind_s1[k];
				plane_s2[k]  <= plane_s1[k];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < rbfi_pkg::NUM_LANES; l++) begin
			inb[l] = (c_s2[l] >= CW'(box_lo[rbfi_pkg::lane_other(l)]))
			      && (c_s2[l] <= CW'(box_hi[rbfi_pkg::lane_other(l)]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
				hit_s3[k] <= !zero_s2[k] && !ovf_s2[2*k] && !ovf_s2[2*k+1]
				          && inb[2*k] && inb[2*k+1];
				behind_s3[k] <= behind_s2[k];
				for (int ax = 0; ax < rbfi_pkg::NUM_AXES; ax++) begin
					if (ax == rbfi_pkg::face_axis(k)) begin
						pt_s3[k][ax] <= plane_s2[k];
					end else if (ax == rbfi_pkg::other_axis(rbfi_pkg::face_axis(k), 0)) begin
						pt_s3[k][ax] <= c_s2[2*k][W-1:0];
					end else begin
						pt_s3[k][ax] <= c_s2[2*k+1][W-1:0];
					end
				end
			end
		end
	end

	always_comb begin
		sel_cnt           = 2'd0;
		sel_first_behind  = 1'b0;
		sel_second_behind = 1'b0;
		for (int ax = 0; ax < rbfi_pkg::NUM_AXES; ax++) begin
			sel_first[ax]  = '0;
			sel_second[ax] = '0;
		end
		for (int k = 0; k < rbfi_pkg::NUM_FACES; k++) begin
			if (hit_s3[k]) begin
				if (sel_cnt == 2'd0) begin
					sel_first        = pt_s3[k];
					sel_first_behind = behind_s3[k];
					sel_cnt          = 2'd1;
				end else if (sel_cnt == 2'd1) begin
					sel_second        = pt_s3[k];
					sel_second_behind = behind_s3[k];
					sel_cnt           = 2'd2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_count_s4     <= sel_cnt;
			first_s4         <= sel_first;
			first_behind_s4  <= sel_first_behind;
			second_s4        <= sel_second;
			second_behind_s4 <= sel_second_behind;
		end
	end

endmodule

// File: hdl/ray_box_face_intersection.sv
`timescale 1ns / 1ps
// Top level: ray against box faces, box registers on the APB port, pipeline control.
// Pipeline: three front stages, one divider stage per quotient bit (COORD_WIDTH + 1),
// and four back stages.
// Throughput is one ray per cycle; the whole pipeline holds while a result beat waits.
// Reset clears all pipeline valid bits and sets the six box bounds to zero.
module ray_box_face_intersection #(
	parameter int  COORD_WIDTH = 32,
	localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int ASH = (COORD_WIDTH > 32) ? 3 : 2,
	localparam int AW  = ASH + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    hit_count,
	output logic signed [COORD_WIDTH-1:0] first_x,
	output logic signed [COORD_WIDTH-1:0] first_y,
	output logic signed [COORD_WIDTH-1:0] first_z,
	output logic                          first_behind,
	output logic signed [COORD_WIDTH-1:0] second_x,
	output logic signed [COORD_WIDTH-1:0] second_y,
	output logic signed [COORD_WIDTH-1:0] second_z,
	output logic                          second_behind,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [AW-1:0]                 paddr,
	input  logic [PDW-1:0]                pwdata,
	output logic [PDW-1:0]                prdata,
	output logic                          pready
);

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] box_q [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] box_lo [rbfi_pkg::NUM_AXES];
	logic signed [W-1:0] box_hi [rbfi_pkg::NUM_AXES];
	logic signed [W-1:0] start_p [rbfi_pkg::NUM_AXES];
	logic signed [W-1:0] end_p [rbfi_pkg::NUM_AXES];
	rbfi_pkg::reg_idx_t  reg_idx;
	logic                wr_en;
	logic                en;

	logic                f_valid;
	logic [W:0]          f_rem [rbfi_pkg::NUM_LANES];
	logic [W:0]          f_low [rbfi_pkg::NUM_LANES];
	logic [W:0]          f_dvs [rbfi_pkg::NUM_LANES];
	logic                f_ovf [rbfi_pkg::NUM_LANES];
	logic                f_neg [rbfi_pkg::NUM_LANES];
	logic signed [W-1:0] f_sb [rbfi_pkg::NUM_LANES];
	logic                f_zero [rbfi_pkg::NUM_FACES];
	logic                f_behind [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] f_plane [rbfi_pkg::NUM_FACES];

	logic                d_valid;
	logic [W:0]          d_quo [rbfi_pkg::NUM_LANES];
	logic                d_rnz [rbfi_pkg::NUM_LANES];
	logic                d_ovf [rbfi_pkg::NUM_LANES];
	logic                d_neg [rbfi_pkg::NUM_LANES];
	logic signed [W-1:0] d_sb [rbfi_pkg::NUM_LANES];
	logic                d_zero [rbfi_pkg::NUM_FACES];
	logic                d_behind [rbfi_pkg::NUM_FACES];
	logic signed [W-1:0] d_plane [rbfi_pkg::NUM_FACES];

	logic signed [W-1:0] first_pt [rbfi_pkg::NUM_AXES];
	logic signed [W-1:0] second_pt [rbfi_pkg::NUM_AXES];

	assign reg_idx = rbfi_pkg::reg_idx_t'(paddr[AW-1:ASH]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbfi_pkg::NUM_FACES; i++) begin
				box_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				rbfi_pkg::REG_MIN_X: box_q[0] <= pwdata[W-1:0];
				rbfi_pkg::REG_MAX_X: box_q[1] <= pwdata[W-1:0];
				rbfi_pkg::REG_MIN_Y: box_q[2] <= pwdata[W-1:0];
				rbfi_pkg::REG_MAX_Y: box_q[3] <= pwdata[W-1:0];
				rbfi_pkg::REG_MIN_Z: box_q[4] <= pwdata[W-1:0];
				rbfi_pkg::REG_MAX_Z: box_q[5] <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rbfi_pkg::REG_MIN_X: prdata = PDW'(box_q[0]);
			rbfi_pkg::REG_MAX_X: prdata = PDW'(box_q[1]);
			rbfi_pkg::REG_MIN_Y: prdata = PDW'(box_q[2]);
			rbfi_pkg::REG_MAX_Y: prdata = PDW'(box_q[3]);
			rbfi_pkg::REG_MIN_Z: prdata = PDW'(box_q[4]);
			rbfi_pkg::REG_MAX_Z: prdata = PDW'(box_q[5]);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		for (int a = 0; a < rbfi_pkg::NUM_AXES; a++) begin
			box_lo[a] = box_q[2*a];
			box_hi[a] = box_q[2*a+1];
		end
		start_p[0] = start_x;
		start_p[1] = start_y;
		start_p[2] = start_z;
		end_p[0]   = end_x;
		end_p[1]   = end_y;
		end_p[2]   = end_z;
	end

	// Every stage moves together; it holds only while the output beat is not taken.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	rbfi_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.start_p   (start_p),
		.end_p     (end_p),
		.box_lo    (box_lo),
		.box_hi    (box_hi),
		.valid_s3  (f_valid),
		.rem_s3    (f_rem),
		.low_s3    (f_low),
		.dvs_s3    (f_dvs),
		.ovf_s3    (f_ovf),
		.neg_s3    (f_neg),
		.sb_s3     (f_sb),
		.zero_s3   (f_zero),
		.behind_s3 (f_behind),
		.plane_s3  (f_plane)
	);

	rbfi_div #(.W(W)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_in   (f_valid),
		.rem_in     (f_rem),
		.low_in     (f_low),
		.dvs_in     (f_dvs),
		.ovf_in     (f_ovf),
		.neg_in     (f_neg),
		.sb_in      (f_sb),
		.zero_in    (f_zero),
		.behind_in  (f_behind),
		.plane_in   (f_plane),
		.valid_out  (d_valid),
		.quo_out    (d_quo),
		.rnz_out    (d_rnz),
		.ovf_out    (d_ovf),
		.neg_out    (d_neg),
		.sb_out     (d_sb),
		.zero_out   (d_zero),
		.behind_out (d_behind),
		.plane_out  (d_plane)
	);

	rbfi_back #(.W(W)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.valid_in         (d_valid),
		.quo              (d_quo),
		.rnz              (d_rnz),
		.ovf              (d_ovf),
		.neg              (d_neg),
		.sb               (d_sb),
		.zero             (d_zero),
		.behind           (d_behind),
		.plane            (d_plane),
		.box_lo           (box_lo),
		.box_hi           (box_hi),
		.valid_s4         (out_valid),
		.hit_count_s4     (hit_count),
		.first_s4         (first_pt),
		.first_behind_s4  (first_behind),
		.second_s4        (second_pt),
		.second_behind_s4 (second_behind)
	);

	assign first_x  = first_pt[0];
	assign first_y  = first_pt[1];
	assign first_z  = first_pt[2];
	assign second_x = second_pt[0];
	assign second_y = second_pt[1];
	assign second_z = second_pt[2];

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_count != 2'd3)
		else $error("hit count out of range");

	a_second_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit_count != 2'd2) |->
		(second_x == '0 && second_y == '0 && second_z == '0 && !second_behind))
		else $error("second hit fields set without a second hit");

	a_first_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit_count == 2'd0) |->
		(first_x == '0 && first_y == '0 && first_z == '0 && !first_behind))
		else $error("first hit fields set without any hit");
`endif

endmodule
